// File: rtl/core/ukvt_pkg.sv
// Package for the unsorted key/value table.
// Holds operation and status codes and the field types shared by the top level and checker.
// Depends on nothing.
package ukvt_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int IDX_W = 7;
	localparam int TOTAL_W = 8;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_LOOKUP = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_PRESENT = 2'd2;
	localparam status_t ST_FULL = 2'd3;

endpackage

// File: rtl/core/unsorted_key_value_table.sv
// Unsorted key/value table with linear search over one key/value RAM.
// Depends on ukvt_pkg and ukvt_ram.
//
//   Channel   Handshake            Fields
//   --------  -------------------  ---------------------------------------------------
//   command   start, busy          op, key, new_value
//   result    done (one cycle)     status, found_index, out_key, out_value, entry_total
//
// A lookup or insert scans the slots in order from slot 0 until the key matches or all
// entries have been read; the RAM read port scans one slot a cycle.
// A remove that finds its key then reads the last entry and writes it into the freed slot;
// a remove that misses takes as long as a lookup.
// An insert into a full table answers in the cycle after acceptance.
// Reset empties the table at once; no clearing pass is needed.
// Results cannot be stalled; busy is low whenever a new command may be issued.
module unsorted_key_value_table #(
	parameter int CAPACITY = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  ukvt_pkg::op_t                      op,
	input  logic signed [ukvt_pkg::KEY_W-1:0]  key,
	input  logic signed [ukvt_pkg::VAL_W-1:0]  new_value,
	output logic                               done,
	output ukvt_pkg::status_t                  status,
	output logic [ukvt_pkg::IDX_W-1:0]         found_index,
	output logic signed [ukvt_pkg::KEY_W-1:0]  out_key,
	output logic signed [ukvt_pkg::VAL_W-1:0]  out_value,
	output logic [ukvt_pkg::TOTAL_W-1:0]       entry_total
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = ukvt_pkg::KEY_W;
	localparam int VW = ukvt_pkg::VAL_W;
	localparam int DW = KW + VW;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RDLAST = 2'd2;
	localparam logic [1:0] S_MOVE = 2'd3;

	logic [1:0]          state_q, state_d;
	ukvt_pkg::op_t       op_q;
	logic [KW-1:0]       key_q;
	logic [VW-1:0]       val_q;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       scan_idx_q;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;
	logic [AW-1:0]       slot_q;
	logic [KW-1:0]       hit_key_q;
	logic [VW-1:0]       hit_val_q;

	logic                accept;
	logic                issue;
	logic                hit;
	logic                miss;
	logic [AW-1:0]       last_addr;

	logic                ram_wr_en;
	logic [AW-1:0]       ram_wr_addr;
	logic [DW-1:0]       ram_wr_data;
	logic                ram_rd_en;
	logic [AW-1:0]       ram_rd_addr;
	logic [DW-1:0]       ram_rd_data;
	logic [KW-1:0]       rd_key;
	logic [VW-1:0]       rd_val;

	logic                res_emit;
	ukvt_pkg::status_t   res_status;
	logic [AW-1:0]       res_idx;
	logic [KW-1:0]       res_key;
	logic [VW-1:0]       res_val;

	logic                done_q;
	ukvt_pkg::status_t   status_q;
	logic [AW-1:0]       idx_q;
	logic [KW-1:0]       out_key_q;
	logic [VW-1:0]       out_val_q;
	logic [CW-1:0]       total_q;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign rd_key = ram_rd_data[DW-1:VW];
	assign rd_val = ram_rd_data[VW-1:0];
	assign last_addr = AW'(count_q - CW'(1));

	// The read issued in the previous cycle returns now; a match ends the scan.
	assign hit = (state_q == S_SCAN) && vld_s1 && (rd_key == key_q);
	assign issue = (state_q == S_SCAN) && !hit && (scan_idx_q < count_q);
	assign miss = (state_q == S_SCAN) && !vld_s1 && !issue;

	assign ram_rd_en = issue || (state_q == S_RDLAST);
	assign ram_rd_addr = (state_q == S_RDLAST) ? last_addr : scan_idx_q[AW-1:0];

	assign ram_wr_en = (miss && (op_q == ukvt_pkg::OP_INSERT)) || (state_q == S_MOVE);
	assign ram_wr_addr = (state_q == S_MOVE) ? slot_q : count_q[AW-1:0];
	assign ram_wr_data = (state_q == S_MOVE) ? ram_rd_data : {key_q, val_q};

	ukvt_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		res_emit = 1'b0;
		res_status = ukvt_pkg::ST_OK;
		res_idx = '0;
		res_key = '0;
		res_val = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == ukvt_pkg::OP_INSERT && count_q == CW'(CAPACITY)) begin
						res_emit = 1'b1;
						res_status = ukvt_pkg::ST_FULL;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (op_q == ukvt_pkg::OP_REMOVE) begin
						state_d = S_RDLAST;
					end else begin
						state_d = S_IDLE;
						res_emit = 1'b1;
						res_status = (op_q == ukvt_pkg::OP_INSERT) ?
							ukvt_pkg::ST_PRESENT : ukvt_pkg::ST_OK;
						res_idx = addr_s1;
						res_key = rd_key;
						res_val = rd_val;
					end
				end else if (miss) begin
					state_d = S_IDLE;
					res_emit = 1'b1;
					if (op_q == ukvt_pkg::OP_INSERT) begin
						res_idx = count_q[AW-1:0];
						res_key = key_q;
						res_val = val_q;
						count_d = count_q + CW'(1);
					end else begin
						res_status = ukvt_pkg::ST_NOT_FOUND;
					end
				end
			end
			S_RDLAST: begin
				state_d = S_MOVE;
			end
			S_MOVE: begin
				// The last entry has been read back and now fills the freed slot.
				state_d = S_IDLE;
				res_emit = 1'b1;
				res_idx = slot_q;
				res_key = hit_key_q;
				res_val = hit_val_q;
				count_d = count_q - CW'(1);
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			vld_s1 <= issue;
			done_q <= res_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			key_q <= key;
			val_q <= new_value;
			scan_idx_q <= '0;
		end else if (issue) begin
			scan_idx_q <= scan_idx_q + CW'(1);
		end
		addr_s1 <= scan_idx_q[AW-1:0];
		if (hit) begin
			slot_q <= addr_s1;
			hit_key_q <= rd_key;
			hit_val_q <= rd_val;
		end
		if (res_emit) begin
			status_q <= res_status;
			idx_q <= res_idx;
			out_key_q <= res_key;
			out_val_q <= res_val;
			total_q <= count_d;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign found_index = ukvt_pkg::IDX_W'(idx_q);
	assign out_key = out_key_q;
	assign out_value = out_val_q;
	assign entry_total = ukvt_pkg::TOTAL_W'(total_q);

endmodule

// File: rtl/core/ukvt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ukvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/ukvt_checker.sv
// Port-level checker for the unsorted key/value table, bound to the top level.
// Depends on ukvt_pkg and unsorted_key_value_table.
module ukvt_checker #(
	parameter int CAPACITY = 128
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input ukvt_pkg::status_t                 status,
	input logic [ukvt_pkg::IDX_W-1:0]        found_index,
	input logic [ukvt_pkg::KEY_W-1:0]        out_key,
	input logic [ukvt_pkg::VAL_W-1:0]        out_value,
	input logic [ukvt_pkg::TOTAL_W-1:0]      entry_total
);

	// An accepted transaction either answers at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction neither answered nor marked busy");

	// The block leaves busy only by delivering a result.
	a_busy_ends_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ukvt_pkg::ST_NOT_FOUND || status == ukvt_pkg::ST_FULL) |->
		found_index == '0 && out_key == '0 && out_value == '0)
		else $error("failed transaction reported nonzero entry fields");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ukvt_pkg::ST_FULL |->
		entry_total == ukvt_pkg::TOTAL_W'(CAPACITY))
		else $error("table full reported with wrong entry total");

endmodule

bind unsorted_key_value_table ukvt_checker #(
	.CAPACITY(CAPACITY)
) u_ukvt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found_index (found_index),
	.out_key     (out_key),
	.out_value   (out_value),
	.entry_total (entry_total)
);
